@@ sv/turtle_symbol_interpreter_defines.svh @@
// assertion macros for the turtle symbol interpreter checker
`ifndef TURTLE_SYMBOL_INTERPRETER_DEFINES_SVH
`define TURTLE_SYMBOL_INTERPRETER_DEFINES_SVH

// same-cycle implication, off while reset is low
`define TSI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("turtle interpreter check failed");

// next-cycle implication, off while reset is low
`define TSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("turtle interpreter check failed");

`endif

@@ sv/tsi_pkg.sv @@
// types and constants of the turtle symbol interpreter
`default_nettype none

package tsi_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       first_symbol;
    } t_in_item;

    typedef struct packed {
        logic              draw_segment;
        logic signed [23:0] from_x;
        logic signed [23:0] from_y;
        logic signed [23:0] to_x;
        logic signed [23:0] to_y;
        logic [1:0]        status;
        logic [6:0]        stack_level;
    } t_out_item;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // command characters
    localparam logic [7:0] SYM_DRAW      = 8'h46; // F
    localparam logic [7:0] SYM_MOVE      = 8'h66; // f
    localparam logic [7:0] SYM_TURN_POS  = 8'h2B; // +
    localparam logic [7:0] SYM_TURN_NEG  = 8'h2D; // -
    localparam logic [7:0] SYM_REVERSE   = 8'h7C; // |
    localparam logic [7:0] SYM_FLIP_TURN = 8'h21; // !
    localparam logic [7:0] SYM_TURN_UP   = 8'h28; // (
    localparam logic [7:0] SYM_TURN_DOWN = 8'h29; // )
    localparam logic [7:0] SYM_LEN_UP    = 8'h3C; // <
    localparam logic [7:0] SYM_LEN_DOWN  = 8'h3E; // >
    localparam logic [7:0] SYM_PUSH      = 8'h5B; // [
    localparam logic [7:0] SYM_POP       = 8'h5D; // ]

    // configuration register map
    localparam int unsigned CFG_AW = 5;
    localparam logic [2:0] REG_START_X       = 3'd0;
    localparam logic [2:0] REG_START_Y       = 3'd1;
    localparam logic [2:0] REG_START_LENGTH  = 3'd2;
    localparam logic [2:0] REG_START_TURN    = 3'd3;
    localparam logic [2:0] REG_START_HEADING = 3'd4;

    localparam logic [23:0] RST_START_X       = 24'd163840;
    localparam logic [23:0] RST_START_Y       = 24'd179200;
    localparam logic [15:0] RST_START_LENGTH  = 16'd1280;
    localparam logic [15:0] RST_START_TURN    = 16'd3641;
    localparam logic [15:0] RST_START_HEADING = 16'd0;

    // q.16 scale factors and rounding
    localparam logic [16:0] UP_Q16    = 17'd72090;
    localparam logic [16:0] DOWN_Q16  = 17'd58982;
    localparam logic [33:0] ROUND_Q16 = 34'd32768;

    localparam logic [15:0] TURN_MAX     = 16'd32767;
    localparam logic [15:0] LEN_MAX      = 16'hFFFF;
    localparam logic [15:0] HALF_TURN    = 16'd32768;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    // sine polynomial, q.14
    localparam logic [14:0] SIN_QUARTER = 15'd16384;
    localparam logic [10:0] SIN_C1      = 11'd1160;
    localparam logic [13:0] SIN_C2      = 14'd10512;
    localparam logic [14:0] SIN_C3      = 15'd25736;
    localparam logic [31:0] MOVE_ROUND  = 32'd8192;

    localparam logic signed [25:0] POS_MAX_W = 26'sd8388607;
    localparam logic signed [25:0] POS_MIN_W = -26'sd8388608;
    localparam logic [23:0]        POS_MAX   = 24'h7FFFFF;
    localparam logic [23:0]        POS_MIN   = 24'h800000;

endpackage

`default_nettype wire

@@ sv/turtle_symbol_interpreter.sv @@
// turtle symbol interpreter: attitude stage, sine/move pipeline, position stage
//
//  port group      direction  transfer when
//  i_in_*          in         i_in_valid high and o_in_stall low
//  o_out_*         out        o_out_valid high and i_out_stall low
//  apb (psel ...)  in/out     psel, penable and pready high; pwrite for writes
//
// one symbol per cycle sustained while o_in_stall stays low; a result passes through
// the sine and projection multiplier chain (six stages) and then the output register
// heading, length and turn update in the input cycle; positions update at the pipe end
// both stacks keep their top entry in registers, so pops never wait for a memory read
// reset is synchronous, no clearing pass; an output stall backs up through the
// pipe stages, which close their bubbles before stalling the input
`default_nettype none

module turtle_symbol_interpreter #(
    parameter int unsigned STACK_DEPTH     = 64,
    parameter int unsigned SINE_INDEX_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tsi_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tsi_pkg::t_out_item             o_out_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsi_pkg::CFG_AW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW  = $clog2(STACK_DEPTH);
    localparam logic [SPW-1:0] DepthSp  = SPW'(STACK_DEPTH);
    localparam logic [15:0]    SineMask = 16'(32'hFFFF << (16 - SINE_INDEX_BITS));

    typedef struct packed {
        logic           draw;
        logic           move;
        logic           reload;
        logic           push;
        logic           pop;
        logic [1:0]     status;
        logic [SPW-1:0] sp_before;
        logic [SPW-1:0] sp_after;
    } t_ctl;

    function automatic logic [23:0] sat_pos(input logic signed [25:0] v);
        logic [23:0] r;
        if (v > tsi_pkg::POS_MAX_W) begin
            r = tsi_pkg::POS_MAX;
        end else if (v < tsi_pkg::POS_MIN_W) begin
            r = tsi_pkg::POS_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [23:0] r_start_x, r_start_y;
    logic [15:0] r_start_length, r_start_turn, r_start_heading;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[tsi_pkg::CFG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x       <= tsi_pkg::RST_START_X;
            r_start_y       <= tsi_pkg::RST_START_Y;
            r_start_length  <= tsi_pkg::RST_START_LENGTH;
            r_start_turn    <= tsi_pkg::RST_START_TURN;
            r_start_heading <= tsi_pkg::RST_START_HEADING;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                tsi_pkg::REG_START_X:       r_start_x       <= pwdata[23:0];
                tsi_pkg::REG_START_Y:       r_start_y       <= pwdata[23:0];
                tsi_pkg::REG_START_LENGTH:  r_start_length  <= pwdata[15:0];
                tsi_pkg::REG_START_TURN:    r_start_turn    <= pwdata[15:0];
                tsi_pkg::REG_START_HEADING: r_start_heading <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            tsi_pkg::REG_START_X:       prdata = {8'd0, r_start_x};
            tsi_pkg::REG_START_Y:       prdata = {8'd0, r_start_y};
            tsi_pkg::REG_START_LENGTH:  prdata = {16'd0, r_start_length};
            tsi_pkg::REG_START_TURN:    prdata = {16'd0, r_start_turn};
            tsi_pkg::REG_START_HEADING: prdata = {16'd0, r_start_heading};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- pipe flow ----------------
    logic [6:1] r_v;
    logic [7:1] adv;
    logic       r_out_valid;
    logic       acc;

    always_comb begin
        adv[7] = !r_out_valid || !i_out_stall;
        for (int k = 6; k >= 1; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign acc         = i_in_valid && adv[1];
    assign o_in_stall  = !adv[1];
    assign o_out_valid = r_out_valid;

    // ---------------- attitude stage ----------------
    logic [15:0]    r_heading, r_length, r_turn;
    logic [SPW-1:0] r_sp;
    logic [47:0]    r_top_att, r_att_below;
    logic [47:0]    r_att_mem [STACK_DEPTH];

    logic [15:0]    cur_heading, cur_length, cur_turn;
    logic [SPW-1:0] cur_sp;
    logic [47:0]    cur_att;
    logic [15:0]    n_heading, n_length, n_turn;
    logic [SPW-1:0] n_sp;
    logic [47:0]    n_top_att;
    t_ctl           a_ctl;

    logic [15:0] turn_mag, turn_mag_sat, sc_turn_mag, sc_in;
    logic [16:0] sc_f;
    logic [33:0] sc_prod;
    logic [17:0] sc_r;
    logic        sc_len, sc_up;
    logic [SPW-1:0] att_rd_sp;
    logic [AW-1:0]  att_ra, att_wa;

    assign cur_heading = i_in_item.first_symbol ? r_start_heading : r_heading;
    assign cur_length  = i_in_item.first_symbol ? r_start_length  : r_length;
    assign cur_turn    = i_in_item.first_symbol ? r_start_turn    : r_turn;
    assign cur_sp      = i_in_item.first_symbol ? '0 : r_sp;
    assign cur_att     = {cur_turn, cur_length, cur_heading};

    assign turn_mag     = cur_turn[15] ? (16'd0 - cur_turn) : cur_turn;
    assign turn_mag_sat = (turn_mag > tsi_pkg::TURN_MAX) ? tsi_pkg::TURN_MAX : turn_mag;

    // one shared scaler for the turn step and the length
    assign sc_len  = (i_in_item.symbol == tsi_pkg::SYM_LEN_UP) ||
                     (i_in_item.symbol == tsi_pkg::SYM_LEN_DOWN);
    assign sc_up   = (i_in_item.symbol == tsi_pkg::SYM_LEN_UP) ||
                     (i_in_item.symbol == tsi_pkg::SYM_TURN_UP);
    assign sc_in   = sc_len ? cur_length : turn_mag;
    assign sc_f    = sc_up ? tsi_pkg::UP_Q16 : tsi_pkg::DOWN_Q16;
    assign sc_prod = 34'(sc_in) * 34'(sc_f) + tsi_pkg::ROUND_Q16;
    assign sc_r    = sc_prod[33:16];
    assign sc_turn_mag = (sc_r > 18'(tsi_pkg::TURN_MAX)) ? tsi_pkg::TURN_MAX : sc_r[15:0];

    always_comb begin
        n_heading = cur_heading;
        n_length  = cur_length;
        n_turn    = cur_turn;
        n_sp      = cur_sp;
        n_top_att = r_top_att;
        a_ctl           = '0;
        a_ctl.reload    = i_in_item.first_symbol;
        a_ctl.status    = tsi_pkg::ST_OK;
        a_ctl.sp_before = cur_sp;
        unique case (i_in_item.symbol) inside
            tsi_pkg::SYM_DRAW: begin
                a_ctl.draw = 1'b1;
                a_ctl.move = 1'b1;
            end
            tsi_pkg::SYM_MOVE:     a_ctl.move = 1'b1;
            tsi_pkg::SYM_TURN_POS: n_heading = cur_heading - cur_turn;
            tsi_pkg::SYM_TURN_NEG: n_heading = cur_heading + cur_turn;
            tsi_pkg::SYM_REVERSE:  n_heading = cur_heading + tsi_pkg::HALF_TURN;
            tsi_pkg::SYM_FLIP_TURN: begin
                n_turn = cur_turn[15] ? turn_mag_sat : (16'd0 - turn_mag_sat);
            end
            tsi_pkg::SYM_TURN_UP, tsi_pkg::SYM_TURN_DOWN: begin
                n_turn = cur_turn[15] ? (16'd0 - sc_turn_mag) : sc_turn_mag;
            end
            tsi_pkg::SYM_LEN_UP, tsi_pkg::SYM_LEN_DOWN: begin
                n_length = (sc_r > 18'(tsi_pkg::LEN_MAX)) ? tsi_pkg::LEN_MAX : sc_r[15:0];
            end
            tsi_pkg::SYM_PUSH: begin
                if (cur_sp >= DepthSp) begin
                    a_ctl.status = tsi_pkg::ST_FULL;
                end else begin
                    a_ctl.push = 1'b1;
                    n_sp       = cur_sp + SPW'(1);
                    n_top_att  = cur_att;
                end
            end
            tsi_pkg::SYM_POP: begin
                if (cur_sp == '0) begin
                    a_ctl.status = tsi_pkg::ST_EMPTY;
                end else begin
                    a_ctl.pop = 1'b1;
                    n_sp      = cur_sp - SPW'(1);
                    {n_turn, n_length, n_heading} = r_top_att;
                    n_top_att = r_att_below;
                end
            end
            default: ;
        endcase
        a_ctl.sp_after = n_sp;
    end

    // prefetch the entry under the top for the next cycle's pop
    assign att_rd_sp = (acc ? n_sp : r_sp) - SPW'(2);
    assign att_ra    = att_rd_sp[AW-1:0];
    assign att_wa    = cur_sp[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (acc && a_ctl.push) begin
            r_att_mem[att_wa] <= cur_att;
        end
        r_att_below <= r_att_mem[att_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= tsi_pkg::RST_START_HEADING;
            r_length  <= tsi_pkg::RST_START_LENGTH;
            r_turn    <= tsi_pkg::RST_START_TURN;
            r_sp      <= '0;
        end else if (acc) begin
            r_heading <= n_heading;
            r_length  <= n_length;
            r_turn    <= n_turn;
            r_sp      <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_top_att <= n_top_att;
        end
    end

    // ---------------- sine and projection pipe (lane 0 sine, lane 1 cosine) ----------------
    t_ctl        r_ctl [1:6];
    logic [15:0] r_len [1:5];
    logic [15:0] r_s1_heading;
    logic [14:0] r_s2_z [2];
    logic [14:0] r_s2_z2 [2];
    logic [1:0]  r_s2_neg;
    logic [13:0] r_s3_t1 [2];
    logic [14:0] r_s3_z2 [2];
    logic [14:0] r_s3_z [2];
    logic [1:0]  r_s3_neg;
    logic [14:0] r_s4_t2 [2];
    logic [14:0] r_s4_z [2];
    logic [1:0]  r_s4_neg;
    logic [14:0] r_s5_s [2];
    logic [1:0]  r_s5_neg;
    logic [17:0] r_s6_p [2];
    logic [1:0]  r_s6_neg;

    logic [15:0] ang [2];
    logic [14:0] fold_z [2];
    logic [29:0] zz [2];
    logic [25:0] c1z2 [2];
    logic [28:0] t1z2 [2];
    logic [28:0] zt2 [2];
    logic [31:0] proj [2];

    always_comb begin
        ang[0] = r_s1_heading & SineMask;
        ang[1] = (r_s1_heading + tsi_pkg::QUARTER_TURN) & SineMask;
        for (int l = 0; l < 2; l++) begin
            // fold odd quadrants back onto the first
            fold_z[l] = ang[l][14] ? (tsi_pkg::SIN_QUARTER - {1'b0, ang[l][13:0]})
                                   : {1'b0, ang[l][13:0]};
            zz[l]   = 30'(fold_z[l]) * 30'(fold_z[l]);
            c1z2[l] = 26'(tsi_pkg::SIN_C1) * 26'(r_s2_z2[l]);
            t1z2[l] = 29'(r_s3_t1[l]) * 29'(r_s3_z2[l]);
            zt2[l]  = 29'(r_s4_z[l]) * 29'(r_s4_t2[l]);
            proj[l] = 32'(r_len[5]) * 32'(r_s5_s[l]) + tsi_pkg::MOVE_ROUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_ctl[1]     <= a_ctl;
            r_len[1]     <= cur_length;
            r_s1_heading <= cur_heading;
        end
        if (adv[2]) begin
            r_ctl[2] <= r_ctl[1];
            r_len[2] <= r_len[1];
            for (int l = 0; l < 2; l++) begin
                r_s2_z[l]   <= fold_z[l];
                r_s2_z2[l]  <= zz[l][28:14];
                r_s2_neg[l] <= ang[l][15];
            end
        end
        if (adv[3]) begin
            r_ctl[3] <= r_ctl[2];
            r_len[3] <= r_len[2];
            r_s3_neg <= r_s2_neg;
            for (int l = 0; l < 2; l++) begin
                r_s3_t1[l] <= tsi_pkg::SIN_C2 - 14'(c1z2[l][25:14]);
                r_s3_z2[l] <= r_s2_z2[l];
                r_s3_z[l]  <= r_s2_z[l];
            end
        end
        if (adv[4]) begin
            r_ctl[4] <= r_ctl[3];
            r_len[4] <= r_len[3];
            r_s4_neg <= r_s3_neg;
            for (int l = 0; l < 2; l++) begin
                r_s4_t2[l] <= tsi_pkg::SIN_C3 - t1z2[l][28:14];
                r_s4_z[l]  <= r_s3_z[l];
            end
        end
        if (adv[5]) begin
            r_ctl[5] <= r_ctl[4];
            r_len[5] <= r_len[4];
            r_s5_neg <= r_s4_neg;
            for (int l = 0; l < 2; l++) begin
                r_s5_s[l] <= zt2[l][28:14];
            end
        end
        if (adv[6]) begin
            r_ctl[6] <= r_ctl[5];
            r_s6_neg <= r_s5_neg;
            for (int l = 0; l < 2; l++) begin
                r_s6_p[l] <= proj[l][31:14];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (adv[7]) begin
                r_out_valid <= r_v[6];
            end
        end
    end

    // ---------------- position stage ----------------
    logic [23:0]    r_pos_x, r_pos_y;
    logic [SPW-1:0] r_sp_p;
    logic [47:0]    r_top_pos, r_pos_below;
    logic [47:0]    r_pos_mem [STACK_DEPTH];
    tsi_pkg::t_out_item r_out_item;

    logic           p_fire;
    t_ctl           c6;
    logic [23:0]    cur_px, cur_py, n_px, n_py;
    logic [47:0]    n_top_pos;
    logic signed [25:0] px_w, py_w, dx, dy_neg;
    logic [SPW-1:0] pos_rd_sp;
    logic [AW-1:0]  pos_ra, pos_wa;
    logic [SPW+6:0] lvl_wide;

    assign p_fire = r_v[6] && adv[7];
    assign c6     = r_ctl[6];
    assign cur_px = c6.reload ? r_start_x : r_pos_x;
    assign cur_py = c6.reload ? r_start_y : r_pos_y;
    assign px_w   = {{2{cur_px[23]}}, cur_px};
    assign py_w   = {{2{cur_py[23]}}, cur_py};
    // dx carries the sine sign, dy_neg is minus the cosine projection
    assign dx     = r_s6_neg[0] ? (26'sd0 - $signed({8'd0, r_s6_p[0]}))
                                : $signed({8'd0, r_s6_p[0]});
    assign dy_neg = r_s6_neg[1] ? $signed({8'd0, r_s6_p[1]})
                                : (26'sd0 - $signed({8'd0, r_s6_p[1]}));

    always_comb begin
        n_px      = cur_px;
        n_py      = cur_py;
        n_top_pos = r_top_pos;
        if (c6.move) begin
            n_px = sat_pos(px_w + dx);
            n_py = sat_pos(py_w + dy_neg);
        end
        if (c6.push) begin
            n_top_pos = {cur_py, cur_px};
        end
        if (c6.pop) begin
            {n_py, n_px} = r_top_pos;
            n_top_pos    = r_pos_below;
        end
    end

    assign pos_rd_sp = (p_fire ? c6.sp_after : r_sp_p) - SPW'(2);
    assign pos_ra    = pos_rd_sp[AW-1:0];
    assign pos_wa    = c6.sp_before[AW-1:0];
    assign lvl_wide  = {7'd0, c6.sp_after};

    always_ff @(posedge i_clk) begin
        if (p_fire && c6.push) begin
            r_pos_mem[pos_wa] <= {cur_py, cur_px};
        end
        r_pos_below <= r_pos_mem[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= tsi_pkg::RST_START_X;
            r_pos_y <= tsi_pkg::RST_START_Y;
            r_sp_p  <= '0;
        end else if (p_fire) begin
            r_pos_x <= n_px;
            r_pos_y <= n_py;
            r_sp_p  <= c6.sp_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_fire) begin
            r_top_pos               <= n_top_pos;
            r_out_item.draw_segment <= c6.draw;
            r_out_item.from_x       <= cur_px;
            r_out_item.from_y       <= cur_py;
            r_out_item.to_x         <= n_px;
            r_out_item.to_y         <= n_py;
            r_out_item.status       <= c6.status;
            r_out_item.stack_level  <= lvl_wide[6:0];
        end
    end

    assign o_out_item = r_out_item;

endmodule

`default_nettype wire

@@ sv/tsi_checker.sv @@
// port-level checks for the turtle symbol interpreter, bound to the top level
`default_nettype none
`include "turtle_symbol_interpreter_defines.svh"

module tsi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input tsi_pkg::t_out_item i_out_item
);

    `TSI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    `TSI_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out_item))
    // a drawn segment never comes with a stack fault
    `TSI_ASSERT_IMPLIES(a_draw_ok, i_clk, i_rst_n, i_out_valid && i_out_item.draw_segment, i_out_item.status == tsi_pkg::ST_OK)
    // a stack fault leaves the position where it was
    `TSI_ASSERT_IMPLIES(a_fault_still, i_clk, i_rst_n, i_out_valid && (i_out_item.status != tsi_pkg::ST_OK), (i_out_item.to_x == i_out_item.from_x) && (i_out_item.to_y == i_out_item.from_y))

endmodule

bind turtle_symbol_interpreter tsi_checker u_tsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

`default_nettype wire

@@ tb/turtle_symbol_interpreter_test.sv @@
// self-checking testbench for the turtle symbol interpreter: scripted symbols, a stack fill, then random strings
`default_nettype none

module turtle_symbol_interpreter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tsi_pkg::*;

    localparam int unsigned DEPTH      = 64;
    localparam int unsigned SINE_BITS  = 12;
    localparam int unsigned SINE_SHIFT = 16 - SINE_BITS;
    localparam int unsigned LIMIT_NS   = 2_000_000;
    localparam int unsigned QUOTA      = 160;

    // symbols the block has no use for
    localparam logic [7:0] SYM_QUERY  = 8'h3F;
    localparam logic [7:0] SYM_ALL_HI = 8'hFF;
    localparam logic [7:0] SYM_ALL_LO = 8'h00;

    localparam int HOME_X  = 163840;
    localparam int HOME_Y  = 179200;
    localparam int HOME_Y1 = 177920;
    localparam int HOME_Y2 = 176640;

    typedef struct {
        logic [7:0] sym;
        bit         first;
        bit         pinned;
        t_out_item  want;
    } script_row_t;

    typedef struct {
        bit        pinned;
        t_out_item want;
    } pin_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // turtle as the block should see it
    logic signed [23:0] pos_x, pos_y;
    logic [15:0]        heading, seg_len;
    logic signed [15:0] turn;
    logic [47:0]        saved_pos [DEPTH];
    logic [47:0]        saved_att [DEPTH];
    int unsigned        sp;

    logic [23:0] cfg_x       = RST_START_X;
    logic [23:0] cfg_y       = RST_START_Y;
    logic [15:0] cfg_len     = RST_START_LENGTH;
    logic [15:0] cfg_turn    = RST_START_TURN;
    logic [15:0] cfg_heading = RST_START_HEADING;

    t_out_item   awaited_reports [$];
    pin_t        table_pins [$];
    t_in_item    symbol_backlog [$];
    script_row_t script [24];
    int unsigned mismatches = 0;
    bit          calm = 1'b0;
    bit          reload_pending = 1'b0;

    turtle_symbol_interpreter #(
        .STACK_DEPTH     (DEPTH),
        .SINE_INDEX_BITS (SINE_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 38);
    end

    function automatic t_out_item report(bit draw, int fx, int fy, int tx, int ty,
                                         logic [1:0] st, int lvl);
        t_out_item rep;
        rep.draw_segment = draw;
        rep.from_x       = fx;
        rep.from_y       = fy;
        rep.to_x         = tx;
        rep.to_y         = ty;
        rep.status       = st;
        rep.stack_level  = lvl;
        return rep;
    endfunction

    function automatic void reload_start();
        pos_x   = cfg_x;
        pos_y   = cfg_y;
        seg_len = cfg_len;
        turn    = cfg_turn;
        heading = cfg_heading;
        sp      = 0;
    endfunction

    // q.14 sine from the truncated heading, folded into the first quadrant
    function automatic int sine_q14(logic [15:0] a);
        logic [15:0] ta;
        int unsigned q, z, z2, t, s;
        ta = (a >> SINE_SHIFT) << SINE_SHIFT;
        q  = ta[15:14];
        z  = ta[13:0];
        if (q[0]) z = SIN_QUARTER - z;
        z2 = (z * z) >> 14;
        t  = SIN_C2 - ((SIN_C1 * z2) >> 14);
        t  = SIN_C3 - ((t * z2) >> 14);
        s  = (z * t) >> 14;
        return (q >= 2) ? -int'(s) : int'(s);
    endfunction

    function automatic int move_delta(logic [15:0] len, int s);
        longint unsigned mag, p;
        mag = (s < 0) ? longint'(-s) : longint'(s);
        p   = (longint'(len) * mag + MOVE_ROUND) >> 14;
        return (s < 0) ? -int'(p) : int'(p);
    endfunction

    function automatic logic signed [23:0] clamp_pos(longint v);
        if (v > POS_MAX_W) return POS_MAX;
        if (v < POS_MIN_W) return POS_MIN;
        return v[23:0];
    endfunction

    function automatic int unsigned scale_q16(int unsigned m, int unsigned f);
        return int'((longint'(m) * f + ROUND_Q16) >> 16);
    endfunction

    function automatic logic signed [15:0] scale_turn(logic signed [15:0] t, int unsigned f);
        int unsigned m, r;
        m = (t < 0) ? -int'(t) : int'(t);
        r = scale_q16(m, f);
        if (r > TURN_MAX) r = TURN_MAX;
        return (t < 0) ? 16'(-int'(r)) : 16'(r);
    endfunction

    function automatic t_out_item advance_turtle(t_in_item it);
        t_out_item   rep;
        int          mag;
        int unsigned r;
        longint      nx, ny;
        if (it.first_symbol) reload_start();
        rep              = '0;
        rep.from_x       = pos_x;
        rep.from_y       = pos_y;
        rep.status       = ST_OK;
        case (it.symbol)
            SYM_DRAW, SYM_MOVE: begin
                rep.draw_segment = (it.symbol == SYM_DRAW);
                nx = longint'(pos_x) + move_delta(seg_len, sine_q14(heading));
                ny = longint'(pos_y) - move_delta(seg_len, sine_q14(16'(heading + QUARTER_TURN)));
                pos_x = clamp_pos(nx);
                pos_y = clamp_pos(ny);
            end
            SYM_TURN_POS:  heading = heading - turn;
            SYM_TURN_NEG:  heading = heading + turn;
            SYM_REVERSE:   heading = heading + HALF_TURN;
            SYM_FLIP_TURN: begin
                mag = (turn < 0) ? -int'(turn) : int'(turn);
                if (mag > TURN_MAX) mag = TURN_MAX;
                turn = (turn < 0) ? 16'(mag) : 16'(-mag);
            end
            SYM_TURN_UP:   turn = scale_turn(turn, UP_Q16);
            SYM_TURN_DOWN: turn = scale_turn(turn, DOWN_Q16);
            SYM_LEN_UP: begin
                r = scale_q16(seg_len, UP_Q16);
                seg_len = (r > LEN_MAX) ? LEN_MAX : r[15:0];
            end
            SYM_LEN_DOWN:  seg_len = 16'(scale_q16(seg_len, DOWN_Q16));
            SYM_PUSH: begin
                if (sp >= DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    saved_pos[sp] = {pos_y, pos_x};
                    saved_att[sp] = {turn, seg_len, heading};
                    sp++;
                end
            end
            SYM_POP: begin
                if (sp == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    sp--;
                    {pos_y, pos_x}           = saved_pos[sp];
                    {turn, seg_len, heading} = saved_att[sp];
                end
            end
            default: ;
        endcase
        rep.to_x        = pos_x;
        rep.to_y        = pos_y;
        rep.stack_level = sp[6:0];
        return rep;
    endfunction

    function automatic bit is_command(logic [7:0] sym);
        case (sym)
            SYM_DRAW, SYM_MOVE, SYM_TURN_POS, SYM_TURN_NEG, SYM_REVERSE, SYM_FLIP_TURN,
            SYM_TURN_UP, SYM_TURN_DOWN, SYM_LEN_UP, SYM_LEN_DOWN, SYM_PUSH, SYM_POP:
                return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want) begin
            if (mismatches < 40) $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // transfers are sampled mid-cycle, where every signal is settled until the next edge
    always @(negedge i_clk) begin : watch
        t_out_item want;
        pin_t      pin;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_reports.size() == 0) begin
                    $error("report with nothing awaited");
                    mismatches++;
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("draw_segment", want.draw_segment, o_out_item.draw_segment);
                    check_field("from_x", want.from_x, o_out_item.from_x);
                    check_field("from_y", want.from_y, o_out_item.from_y);
                    check_field("to_x", want.to_x, o_out_item.to_x);
                    check_field("to_y", want.to_y, o_out_item.to_y);
                    check_field("status", want.status, o_out_item.status);
                    check_field("stack_level", want.stack_level, o_out_item.stack_level);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = advance_turtle(i_in_item);
                pin  = table_pins.pop_front();
                if (pin.pinned) want = pin.want;
                awaited_reports.push_back(want);
            end
        end
    end

    task automatic send_symbol(input logic [7:0] sym, input bit first, input bit pinned,
                               input t_out_item want);
        bit taken;
        while (!calm && $urandom_range(0, 99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        table_pins.push_back('{pinned, want});
        i_in_valid <= 1'b1;
        i_in_item  <= '{symbol: sym, first_symbol: first};
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        bit rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_X:       cfg_x       = val[23:0];
            REG_START_Y:       cfg_y       = val[23:0];
            REG_START_LENGTH:  cfg_len     = val[15:0];
            REG_START_TURN:    cfg_turn    = val[15:0];
            REG_START_HEADING: cfg_heading = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic void add_symbol(logic [7:0] sym);
        symbol_backlog.push_back('{symbol: sym, first_symbol: reload_pending});
        reload_pending = 1'b0;
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 13))
            0, 1, 2, 3, 13: return SYM_DRAW;
            4:  return SYM_MOVE;
            5:  return SYM_TURN_POS;
            6:  return SYM_TURN_NEG;
            7:  return SYM_REVERSE;
            8:  return SYM_FLIP_TURN;
            9:  return SYM_TURN_UP;
            10: return SYM_TURN_DOWN;
            11: return SYM_LEN_UP;
            default: return SYM_LEN_DOWN;
        endcase
    endfunction

    // mostly bracketed strings, some deep nesting to fill the stack, some junk
    function automatic void queue_string();
        int kind, n, depth, r;
        if ($urandom_range(0, 99) < 4) reload_pending = 1'b1;
        kind = $urandom_range(0, 99);
        if (kind < 78) begin
            n     = $urandom_range(4, 20);
            depth = 0;
            for (int k = 0; k < n; k++) begin
                r = $urandom_range(0, 99);
                if (r < 18 && depth < 8) begin
                    add_symbol(SYM_PUSH);
                    depth++;
                end else if (r < 32 && depth > 0) begin
                    add_symbol(SYM_POP);
                    depth--;
                end else begin
                    add_symbol(pick_command());
                end
            end
            while (depth > 0) begin
                add_symbol(SYM_POP);
                depth--;
            end
        end else if (kind < 82) begin
            n = $urandom_range(56, 70);
            repeat (n) add_symbol(SYM_PUSH);
            add_symbol(SYM_DRAW);
            repeat (n + 1) add_symbol(SYM_POP);
        end else if (kind < 94) begin
            repeat ($urandom_range(1, 4)) add_symbol(8'($urandom_range(0, 255)));
        end else begin
            add_symbol($urandom_range(0, 1) ? SYM_PUSH : SYM_POP);
        end
    endfunction

    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [23:0] sx, input logic [23:0] sy,
                             input logic [15:0] slen, input logic [15:0] sturn,
                             input logic [15:0] shead, input bit quiet);
        int unsigned commands_sent;
        t_in_item    it;
        drain_reports();
        write_register(REG_START_X, 32'(sx));
        write_register(REG_START_Y, 32'(sy));
        write_register(REG_START_LENGTH, 32'(slen));
        write_register(REG_START_TURN, 32'(sturn));
        write_register(REG_START_HEADING, 32'(shead));
        calm           = quiet;
        reload_pending = 1'b1;
        symbol_backlog.delete();
        commands_sent  = 0;
        while (commands_sent < QUOTA) begin
            if (symbol_backlog.size() == 0) queue_string();
            it = symbol_backlog.pop_front();
            send_symbol(it.symbol, it.first_symbol, 1'b0, '0);
            if (is_command(it.symbol)) commands_sent++;
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        foreach (saved_pos[k]) begin
            saved_pos[k] = '0;
            saved_att[k] = '0;
        end
        reload_start();

        script = '{
            '{SYM_QUERY, 1'b0, 1'b1, report(0, HOME_X, HOME_Y, HOME_X, HOME_Y, ST_OK, 0)},
            '{SYM_POP, 1'b0, 1'b1, report(0, HOME_X, HOME_Y, HOME_X, HOME_Y, ST_EMPTY, 0)},
            '{SYM_DRAW, 1'b1, 1'b1, report(1, HOME_X, HOME_Y, HOME_X, HOME_Y1, ST_OK, 0)},
            '{SYM_PUSH, 1'b0, 1'b1, report(0, HOME_X, HOME_Y1, HOME_X, HOME_Y1, ST_OK, 1)},
            '{SYM_MOVE, 1'b0, 1'b1, report(0, HOME_X, HOME_Y1, HOME_X, HOME_Y2, ST_OK, 1)},
            '{SYM_POP, 1'b0, 1'b1, report(0, HOME_X, HOME_Y2, HOME_X, HOME_Y1, ST_OK, 0)},
            '{SYM_POP, 1'b0, 1'b1, report(0, HOME_X, HOME_Y1, HOME_X, HOME_Y1, ST_EMPTY, 0)},
            '{SYM_REVERSE, 1'b0, 1'b1, report(0, HOME_X, HOME_Y1, HOME_X, HOME_Y1, ST_OK, 0)},
            '{SYM_DRAW, 1'b0, 1'b1, report(1, HOME_X, HOME_Y1, HOME_X, HOME_Y, ST_OK, 0)},
            '{SYM_TURN_POS, 1'b0, 1'b0, '0},
            '{SYM_DRAW, 1'b0, 1'b0, '0},
            '{SYM_TURN_NEG, 1'b0, 1'b0, '0},
            '{SYM_TURN_NEG, 1'b0, 1'b0, '0},
            '{SYM_MOVE, 1'b0, 1'b0, '0},
            '{SYM_FLIP_TURN, 1'b0, 1'b0, '0},
            '{SYM_TURN_UP, 1'b0, 1'b0, '0},
            '{SYM_TURN_DOWN, 1'b0, 1'b0, '0},
            '{SYM_LEN_UP, 1'b0, 1'b0, '0},
            '{SYM_DRAW, 1'b0, 1'b0, '0},
            '{SYM_LEN_DOWN, 1'b0, 1'b0, '0},
            '{SYM_DRAW, 1'b0, 1'b0, '0},
            '{SYM_ALL_HI, 1'b0, 1'b0, '0},
            '{SYM_ALL_LO, 1'b0, 1'b0, '0},
            '{SYM_DRAW, 1'b1, 1'b1, report(1, HOME_X, HOME_Y, HOME_X, HOME_Y1, ST_OK, 0)}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) send_symbol(script[k].sym, script[k].first, script[k].pinned,
                                        script[k].want);

        // fill the stack, overflow it once, then empty it and underflow it
        repeat (DEPTH) send_symbol(SYM_PUSH, 1'b0, 1'b0, '0);
        send_symbol(SYM_PUSH, 1'b0, 1'b1,
                    report(0, HOME_X, HOME_Y1, HOME_X, HOME_Y1, ST_FULL, DEPTH));
        repeat (DEPTH) send_symbol(SYM_POP, 1'b0, 1'b0, '0);
        send_symbol(SYM_POP, 1'b0, 1'b1,
                    report(0, HOME_X, HOME_Y1, HOME_X, HOME_Y1, ST_EMPTY, 0));

        run_phase(POS_MAX, POS_MIN, LEN_MAX, 16'h8000, 16'hFFFF, 1'b0);
        run_phase(POS_MIN, POS_MAX, 16'd0, TURN_MAX, HALF_TURN, 1'b0);
        run_phase(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'b1);
        run_phase(24'($urandom), 24'($urandom), 16'($urandom_range(0, 4095)),
                  16'($urandom), 16'($urandom), 1'b0);
        run_phase(RST_START_X, RST_START_Y, RST_START_LENGTH, RST_START_TURN,
                  RST_START_HEADING, 1'b0);

        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/tsi_pkg.sv
sv/turtle_symbol_interpreter.sv
sv/tsi_checker.sv
tb/turtle_symbol_interpreter_test.sv
